### rtl/core/ctp_pkg.sv
// ctp_pkg: shared codes for the ceiling take pool
// no dependencies
`timescale 1ns / 1ps

package ctp_pkg;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned StatusWidth = 2;

  // operation codes carried on func_i
  localparam logic FuncInsert = 1'b0;
  localparam logic FuncQuery  = 1'b1;

  // result status codes
  localparam logic [StatusWidth-1:0] StatusDone  = 2'd0;
  localparam logic [StatusWidth-1:0] StatusFull  = 2'd1;
  localparam logic [StatusWidth-1:0] StatusEmpty = 2'd2;

  typedef logic signed [ValueWidth-1:0] value_t;

endpackage

### rtl/core/ceiling_take_pool.sv
// ceiling_take_pool: pool of signed values with a greedy ceiling-take query
// depends on ctp_pkg; holds the pool memory and its scan sequencer
// insert: word accepted at one edge, result strobed on done_o the next cycle, one per cycle while busy is low
// query: result strobed on done_o after the scan and the S_WRITE state, busy high till then
// query time is set by the scan loop, one pool memory read per cycle
// next word can go in at the edge that ends the result cycle
// empty pool query or full pool insert: result the next cycle, pool untouched
// async active-low reset empties the pool; memory contents stay undefined
`timescale 1ns / 1ps

module ceiling_take_pool
  import ctp_pkg::*;
#(
  parameter int unsigned POOL_DEPTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   func_i,
  input  logic signed [31:0]     operand_value_i,
  output logic                   done_o,
  output logic signed [31:0]     taken_value_o,
  output logic                   used_fallback_o,
  output logic [StatusWidth-1:0] status_o
);

  localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CW = $clog2(POOL_DEPTH + 1);
  localparam logic [CW-1:0] DepthCount = CW'(POOL_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_e;

  // sequencer state
  state_e          state_q;
  logic [CW-1:0]   count_q;     // entries held
  logic [CW-1:0]   cnt_q;       // next scan address to issue
  logic            rvalid_q;    // read data in rdata_q belongs to the scan
  logic [CW-1:0]   ridx_q;      // pool position of rdata_q
  value_t          thr_q;       // query threshold
  logic            have_ceil_q; // some entry reached the threshold
  value_t          ceil_val_q;
  logic [AW-1:0]   ceil_pos_q;
  value_t          min_val_q;
  logic [AW-1:0]   min_pos_q;
  value_t          last_q;      // top entry, moved into the hole on removal

  // pool memory, one write and one registered read per cycle
  value_t          mem_q [POOL_DEPTH];
  value_t          rdata_q;
  logic            we;
  logic [AW-1:0]   waddr;
  value_t          wdata;
  logic [AW-1:0]   raddr;

  logic            accept;
  logic            last_entry;
  logic            v_ge;
  logic            ceil_better;
  logic            min_better;
  logic [AW-1:0]   take_pos;
  logic [CW-1:0]   count_m1;

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign count_m1 = count_q - CW'(1);

  // shared compare unit: one entry per cycle against threshold, best ceiling, minimum
  assign v_ge        = (rdata_q >= thr_q);
  assign ceil_better = v_ge && (!have_ceil_q || (rdata_q < ceil_val_q));
  assign min_better  = (ridx_q == '0) || (rdata_q < min_val_q);
  assign last_entry  = rvalid_q && (ridx_q == count_m1);
  assign take_pos    = have_ceil_q ? ceil_pos_q : min_pos_q;
  assign raddr       = cnt_q[AW-1:0];

  // order inside the pool does not show in any result, so a removal
  // fills the hole with the top entry instead of shifting everything down
  always_comb begin
    we    = 1'b0;
    waddr = count_q[AW-1:0];
    wdata = operand_value_i;
    if (accept && (func_i == FuncInsert) && (count_q < DepthCount)) begin
      we = 1'b1;
    end else if (state_q == S_WRITE) begin
      we    = 1'b1;
      waddr = take_pos;
      wdata = last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      count_q         <= '0;
      cnt_q           <= '0;
      rvalid_q        <= 1'b0;
      ridx_q          <= '0;
      thr_q           <= '0;
      have_ceil_q     <= 1'b0;
      ceil_val_q      <= '0;
      ceil_pos_q      <= '0;
      min_val_q       <= '0;
      min_pos_q       <= '0;
      last_q          <= '0;
      done_o          <= 1'b0;
      taken_value_o   <= '0;
      used_fallback_o <= 1'b0;
      status_o        <= StatusDone;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (func_i == FuncInsert) begin
              // word goes straight into the memory unless the pool is full, result next cycle
              done_o          <= 1'b1;
              taken_value_o   <= '0;
              used_fallback_o <= 1'b0;
              if (count_q < DepthCount) begin
                count_q  <= count_q + CW'(1);
                status_o <= StatusDone;
              end else begin
                status_o <= StatusFull;
              end
            end else if (count_q == '0) begin
              done_o          <= 1'b1;
              taken_value_o   <= '0;
              used_fallback_o <= 1'b0;
              status_o        <= StatusEmpty;
            end else begin
              thr_q       <= operand_value_i;
              cnt_q       <= '0;
              rvalid_q    <= 1'b0;
              have_ceil_q <= 1'b0;
              state_q     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // issue side: one read per cycle until every entry is out
          rvalid_q <= (cnt_q < count_q);
          ridx_q   <= cnt_q;
          if (cnt_q < count_q) begin
            cnt_q <= cnt_q + CW'(1);
          end
          // compare side, on the read issued the cycle before
          if (rvalid_q) begin
            if (ceil_better) begin
              have_ceil_q <= 1'b1;
              ceil_val_q  <= rdata_q;
              ceil_pos_q  <= ridx_q[AW-1:0];
            end
            if (min_better) begin
              min_val_q <= rdata_q;
              min_pos_q <= ridx_q[AW-1:0];
            end
          end
          if (last_entry) begin
            last_q   <= rdata_q;
            rvalid_q <= 1'b0;
            state_q  <= S_WRITE;
          end
        end
        S_WRITE: begin
          // hole filled by the memory write above, pool shrinks by one
          count_q         <= count_m1;
          done_o          <= 1'b1;
          taken_value_o   <= have_ceil_q ? ceil_val_q : min_val_q;
          used_fallback_o <= !have_ceil_q;
          status_o        <= StatusDone;
          state_q         <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // pool never holds more than its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCount)
    else $error("pool count above depth");

  // a scan only runs on a non-empty pool
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (count_q != '0))
    else $error("scan running on empty pool");

  // full report only when the pool really is full
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == StatusFull)) |-> (count_q == DepthCount))
    else $error("full status with room left");

  // fallback flag only on a successful query
  a_fallback_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && used_fallback_o) |-> (status_o == StatusDone))
    else $error("fallback flag on error result");

  // a query result always shrinks the pool by one
  a_take_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |=> (done_o && (count_q == $past(count_m1))))
    else $error("query result without removal");

endmodule

### sim/ceiling_take_pool_tb.sv
// ceiling_take_pool_tb: self-checking bench for the ceiling take pool
// depends on ctp_pkg and ceiling_take_pool; a directed table, then random phases
// checked word by word against a behavioral pool model
`timescale 1ns / 1ps

module ceiling_take_pool_tb;
  import ctp_pkg::*;

  localparam int unsigned POOL_DEPTH   = 64;
  localparam int unsigned RANDOM_WORDS = 1530;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned NUM_DIRECTED = 18;

  localparam value_t VALUE_MAX = 32'sh7FFF_FFFF;
  localparam value_t VALUE_MIN = 32'sh8000_0000;

  // one result word as the block reports it
  typedef struct packed {
    value_t                 taken;
    logic                   fallback;
    logic [StatusWidth-1:0] status;
  } outcome_t;

  // one row of the directed part; typed rows carry their own answer
  typedef struct packed {
    logic     func;
    value_t   operand;
    logic     typed;
    outcome_t want;
  } step_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic                   func_i;
  value_t                 operand_value_i;
  logic                   done_o;
  value_t                 taken_value_o;
  logic                   used_fallback_o;
  logic [StatusWidth-1:0] status_o;

  // pool model in insertion order, and the results still owed by the block
  value_t    pool_model[$];
  outcome_t  pending_results[$];

  // side info for the word currently offered on the inputs
  logic      cur_typed;
  outcome_t  cur_want;

  step_row_t directed_steps [NUM_DIRECTED];

  int unsigned error_count;
  int unsigned stall_cycles;
  int unsigned burst_left;
  int unsigned random_sent;

  outcome_t  got_result;
  outcome_t  owed_result;
  outcome_t  model_result;

  ceiling_take_pool #(
    .POOL_DEPTH(POOL_DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .operand_value_i(operand_value_i),
    .done_o         (done_o),
    .taken_value_o  (taken_value_o),
    .used_fallback_o(used_fallback_o),
    .status_o       (status_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // apply one word to the pool model and return the result it should give
  function automatic outcome_t predict_take(input logic f, input value_t v);
    outcome_t r;
    int       ceil_pos;
    int       min_pos;
    bit       have_ceil;
    r = '{taken: '0, fallback: 1'b0, status: StatusDone};
    have_ceil = 1'b0;
    ceil_pos = 0;
    min_pos = 0;
    if (f == FuncInsert) begin
      // a full pool drops the insert
      if (pool_model.size() >= POOL_DEPTH) r.status = StatusFull;
      else pool_model.push_back(v);
    end else if (pool_model.size() == 0) begin
      r.status = StatusEmpty;
    end else begin
      // strict compares keep the lowest position among equal values
      for (int i = 0; i < pool_model.size(); i++) begin
        if (pool_model[i] >= v && (!have_ceil || pool_model[i] < pool_model[ceil_pos])) begin
          have_ceil = 1'b1;
          ceil_pos = i;
        end
        if (pool_model[i] < pool_model[min_pos]) min_pos = i;
      end
      if (have_ceil) begin
        r.taken = pool_model[ceil_pos];
        pool_model.delete(ceil_pos);
      end else begin
        // nothing reaches the threshold: take the minimum instead
        r.taken = pool_model[min_pos];
        r.fallback = 1'b1;
        pool_model.delete(min_pos);
      end
    end
    return r;
  endfunction

  // values lean toward extremes and a narrow band so equal values show up
  function automatic value_t rand_value();
    case ($urandom_range(0, 7))
      0: return VALUE_MAX;
      1: return VALUE_MIN;
      2, 3: return value_t'($urandom_range(0, 16)) - 8;
      default: return value_t'($urandom);
    endcase
  endfunction

  // offer one word and hold it until accepted; called right after a falling edge
  task automatic send_word(input logic f, input value_t v, input logic typed,
                           input outcome_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      // end of a burst: idle for a while or not at all, then pick the next burst length
      case ($urandom_range(0, 7))
        0: gap = $urandom_range(10, 30);
        1, 2: gap = 0;
        default: gap = $urandom_range(1, 8);
      endcase
      if (gap != 0) begin
        start = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      // now and then a long stretch with no idling at all
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 24);
    end
    start = 1'b1;
    func_i = f;
    operand_value_i = v;
    cur_typed = typed;
    cur_want = want;
    // word is taken at the rising edge where busy is low
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    burst_left--;
  endtask

  // drop start and sit until every owed result has come back
  task automatic wait_for_results();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // monitor: checks results, records accepted words, feeds the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        got_result = '{taken: taken_value_o, fallback: used_fallback_o, status: status_o};
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: taken %0d fallback %0b status %0d",
                   $time, got_result.taken, got_result.fallback, got_result.status);
          error_count++;
        end else begin
          owed_result = pending_results.pop_front();
          if (got_result.taken !== owed_result.taken) begin
            $display("%0t: taken_value mismatch: expected %0d actual %0d",
                     $time, owed_result.taken, got_result.taken);
            error_count++;
          end
          if (got_result.fallback !== owed_result.fallback) begin
            $display("%0t: used_fallback mismatch: expected %0b actual %0b",
                     $time, owed_result.fallback, got_result.fallback);
            error_count++;
          end
          if (got_result.status !== owed_result.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, owed_result.status, got_result.status);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        // the model always steps, so its pool follows typed rows too
        model_result = predict_take(func_i, operand_value_i);
        pending_results.push_back(cur_typed ? cur_want : model_result);
      end
      if (done_o || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  // watchdog: too long with no word moving either way
  initial begin
    stall_cycles = 0;
    wait (stall_cycles >= STALL_LIMIT);
    $display("ceiling_take_pool verification failed");
    $finish;
  end

  // stimulus
  initial begin
    longint      thr;
    int unsigned count;
    int unsigned spread;

    rst_ni = 1'b0;
    start = 1'b0;
    func_i = FuncInsert;
    operand_value_i = '0;
    cur_typed = 1'b0;
    cur_want = '0;
    error_count = 0;
    burst_left = 0;
    random_sent = 0;

    // typed rows: empty query, plain inserts, the highest threshold
    directed_steps = '{
      '{FuncQuery,  32'sd0,         1'b1, '{32'sd0, 1'b0, StatusEmpty}},
      '{FuncInsert, VALUE_MAX,      1'b1, '{32'sd0, 1'b0, StatusDone}},
      '{FuncInsert, VALUE_MIN,      1'b1, '{32'sd0, 1'b0, StatusDone}},
      '{FuncInsert, 32'sd0,         1'b1, '{32'sd0, 1'b0, StatusDone}},
      '{FuncInsert, 32'sd5,         1'b1, '{32'sd0, 1'b0, StatusDone}},
      '{FuncInsert, 32'sd5,         1'b1, '{32'sd0, 1'b0, StatusDone}},
      '{FuncInsert, -32'sd3,        1'b1, '{32'sd0, 1'b0, StatusDone}},
      '{FuncQuery,  VALUE_MAX,      1'b1, '{VALUE_MAX, 1'b0, StatusDone}},
      '{FuncQuery,  VALUE_MAX,      1'b1, '{VALUE_MIN, 1'b1, StatusDone}},
      // equal values, fallback on a threshold above every value, lowest threshold
      '{FuncQuery,  32'sd5,         1'b0, '0},
      '{FuncQuery,  32'sd6,         1'b0, '0},
      '{FuncQuery,  VALUE_MIN,      1'b0, '0},
      '{FuncQuery,  32'sd0,         1'b0, '0},
      '{FuncQuery,  32'sd0,         1'b1, '{32'sd0, 1'b0, StatusEmpty}},
      '{FuncInsert, 32'shAAAA_AAAA, 1'b1, '{32'sd0, 1'b0, StatusDone}},
      '{FuncInsert, 32'sh5555_5555, 1'b1, '{32'sd0, 1'b0, StatusDone}},
      '{FuncQuery,  -32'sd1,        1'b0, '0},
      '{FuncQuery,  32'sd0,         1'b0, '0}
    };

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_word(directed_steps[i].func, directed_steps[i].operand,
                directed_steps[i].typed, directed_steps[i].want);
    end
    // hold off until the directed part has fully drained
    wait_for_results();

    while (random_sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // greedy round: load some values, then thresholds in descending order
          count = $urandom_range(1, 20);
          repeat (count) begin
            send_word(FuncInsert, rand_value(), 1'b0, '0);
            random_sent++;
          end
          spread = ($urandom_range(0, 1) != 0) ? 4 : 32'h7FFF_FFFF;
          thr = longint'(rand_value());
          repeat ($urandom_range(1, count + 2)) begin
            send_word(FuncQuery, value_t'(thr), 1'b0, '0);
            random_sent++;
            thr = thr - longint'($urandom_range(0, spread));
            if (thr < longint'(VALUE_MIN)) thr = longint'(VALUE_MIN);
          end
        end
        4, 5: begin
          // fill to the top and push a few inserts into the full pool
          count = POOL_DEPTH - pool_model.size() + $urandom_range(1, 3);
          repeat (count) begin
            send_word(FuncInsert, rand_value(), 1'b0, '0);
            random_sent++;
          end
        end
        6: begin
          // drain everything, then query the empty pool
          count = pool_model.size() + $urandom_range(1, 3);
          repeat (count) begin
            send_word(FuncQuery, rand_value(), 1'b0, '0);
            random_sent++;
          end
        end
        default: begin
          // noise: random mix of inserts and queries
          repeat ($urandom_range(5, 30)) begin
            send_word(($urandom_range(0, 1) != 0) ? FuncQuery : FuncInsert,
                      rand_value(), 1'b0, '0);
            random_sent++;
          end
        end
      endcase
      if ($urandom_range(0, 5) == 0) wait_for_results();
    end

    // let the last results land, then watch for strays over one full scan
    wait_for_results();
    repeat (POOL_DEPTH + 8) @(negedge clk_i);
    if (error_count == 0) begin
      $display("ceiling_take_pool verification clean");
    end else begin
      $display("ceiling_take_pool verification failed");
    end
    $finish;
  end

endmodule
